### design/assert_macros.svh
// assertion macros shared by the sampler modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/hbs_pkg.sv
// shared types, codes and constants of the height grid sampler
`default_nettype none

package hbs_pkg;

  localparam int DEF_MAX_SIDE = 256;
  localparam int HEIGHT_BITS  = 16;
  localparam int FRAC_BITS    = 8;
  localparam int SCALE_FRAC   = 8;
  localparam int COORD_W      = 24;
  localparam int SCALE_W      = 16;
  localparam int GRID_SIDE_W  = 9;
  localparam int INDEX_W      = 16;
  localparam int ACTION_W     = 2;
  localparam int OUT_W        = 24;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_INDEX_W  = 1;
  localparam int MIN_SIDE     = 2;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [GRID_SIDE_W-1:0] GRID_SIDE_RST = 9'd256;
  localparam logic [SCALE_W-1:0]     INV_SCALE_RST = 16'd256;

  localparam logic signed [HEIGHT_BITS-1:0] HEIGHT_MAX = 16'sh7fff;
  localparam logic signed [HEIGHT_BITS-1:0] HEIGHT_MIN = 16'sh8000;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_LOAD    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_WORLD   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_AVERAGE = 2'd2;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_GRID_SIDE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_INV_SCALE = 1'd1;

  // what the back end has to do with an item
  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_LOAD,
    KIND_BASE,
    KIND_BILINEAR,
    KIND_AVERAGE
  } kind_t;

  typedef struct packed {
    kind_t                          kind;
    logic                           oog;
    logic [FRAC_BITS-1:0]           fx;
    logic [FRAC_BITS-1:0]           fz;
    logic signed [HEIGHT_BITS-1:0]  height;
  } cmd_t;

endpackage

`default_nettype wire

### design/hbs_queue.sv
// small fifo between the classifying front end and the back end
`default_nettype none
`include "assert_macros.svh"

module hbs_queue #(
  parameter int DEPTH = hbs_pkg::QUEUE_DEPTH,
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        slots[wr_ptr] <= wdata;
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  `ASSERT_IMPLIES(a_no_overflow, clk, rst, push, !full, "queue written while full")
  `ASSERT_IMPLIES(a_no_underflow, clk, rst, pop, !empty, "queue read while empty")

endmodule

`default_nettype wire

### design/hbs_front.sv
// front end: accepts beats, scales world coordinates, classifies and addresses
`default_nettype none

module hbs_front #(
  parameter int MAX_SIDE = hbs_pkg::DEF_MAX_SIDE
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [hbs_pkg::ACTION_W-1:0]           action,
  input  logic [hbs_pkg::INDEX_W-1:0]            sample_index,
  input  logic signed [hbs_pkg::HEIGHT_BITS-1:0] sample_height,
  input  logic [hbs_pkg::COORD_W-1:0]            coord_x,
  input  logic [hbs_pkg::COORD_W-1:0]            coord_z,
  input  logic [hbs_pkg::SCALE_W-1:0]            inv_scale,
  input  logic [$clog2(MAX_SIDE+1)-1:0]          side,
  input  logic [$clog2(MAX_SIDE*MAX_SIDE+1)-1:0] side_sq,
  input  logic                                   q_full,
  output logic                                   q_push,
  output hbs_pkg::cmd_t                          q_cmd,
  output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]   q_addr
);

  localparam int F      = hbs_pkg::FRAC_BITS;
  localparam int COORD_W = hbs_pkg::COORD_W;
  localparam int PROD_W = hbs_pkg::COORD_W + hbs_pkg::SCALE_W;
  localparam int SC_W   = PROD_W - hbs_pkg::SCALE_FRAC;
  localparam int CX_W   = SC_W - F;
  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int CELL_W = $clog2(MAX_SIDE);
  localparam int ADDR_W = $clog2(MAX_SIDE * MAX_SIDE);
  localparam int SQ_W   = $clog2(MAX_SIDE * MAX_SIDE + 1);
  localparam int IDX_CMP_W = (hbs_pkg::INDEX_W > SQ_W) ? hbs_pkg::INDEX_W : SQ_W;
  localparam int MUL_W  = CELL_W + SIDE_W;

  logic                                   s1_valid;
  logic [hbs_pkg::ACTION_W-1:0]           s1_action;
  logic [hbs_pkg::INDEX_W-1:0]            s1_index;
  logic signed [hbs_pkg::HEIGHT_BITS-1:0] s1_height;
  logic [COORD_W-1:0]                     s1_cx;
  logic [COORD_W-1:0]                     s1_cz;

  logic                                   s2_valid;
  logic [hbs_pkg::ACTION_W-1:0]           s2_action;
  logic [hbs_pkg::INDEX_W-1:0]            s2_index;
  logic signed [hbs_pkg::HEIGHT_BITS-1:0] s2_height;
  logic [SC_W-1:0]                        s2_cx;
  logic [SC_W-1:0]                        s2_cz;

  logic            s2_free;
  logic            s1_adv;
  logic            accept;
  logic [PROD_W-1:0] prod_x;
  logic [PROD_W-1:0] prod_z;
  logic [SC_W-1:0] scaled_x;
  logic [SC_W-1:0] scaled_z;

  logic [CX_W-1:0]   ix;
  logic [CX_W-1:0]   iz;
  logic              x_in;
  logic              z_in;
  logic              x_last;
  logic              z_last;
  logic [MUL_W-1:0]  row_base;
  logic [ADDR_W-1:0] grid_addr;

  assign q_push   = s2_valid && !q_full;
  assign s2_free  = !s2_valid || q_push;
  assign s1_adv   = s1_valid && s2_free;
  assign in_stall = s1_valid && !s2_free;
  assign accept   = in_valid && !in_stall;

  // world mode: Q16.8 coordinate times Q8.8 inverse scale
  always_comb begin
    prod_x = PROD_W'(s1_cx) * PROD_W'(inv_scale);
    prod_z = PROD_W'(s1_cz) * PROD_W'(inv_scale);
    if (s1_action == hbs_pkg::ACT_WORLD) begin
      scaled_x = prod_x[PROD_W-1:hbs_pkg::SCALE_FRAC];
      scaled_z = prod_z[PROD_W-1:hbs_pkg::SCALE_FRAC];
    end else begin
      scaled_x = SC_W'(s1_cx);
      scaled_z = SC_W'(s1_cz);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= accept || (s1_valid && !s2_free);
      s2_valid <= s1_adv || (s2_valid && !q_push);
      if (accept) begin
        s1_action <= action;
        s1_index  <= sample_index;
        s1_height <= sample_height;
        s1_cx     <= coord_x;
        s1_cz     <= coord_z;
      end
      if (s1_adv) begin
        s2_action <= s1_action;
        s2_index  <= s1_index;
        s2_height <= s1_height;
        s2_cx     <= scaled_x;
        s2_cz     <= scaled_z;
      end
    end
  end

  // cell position, range and edge checks
  always_comb begin
    ix        = s2_cx[SC_W-1:F];
    iz        = s2_cz[SC_W-1:F];
    x_in      = ix < CX_W'(side);
    z_in      = iz < CX_W'(side);
    x_last    = ((CX_W+1)'(ix) + (CX_W+1)'(1)) >= (CX_W+1)'(side);
    z_last    = ((CX_W+1)'(iz) + (CX_W+1)'(1)) >= (CX_W+1)'(side);
    row_base  = MUL_W'(iz[CELL_W-1:0]) * MUL_W'(side);
    grid_addr = ADDR_W'(row_base + MUL_W'(ix[CELL_W-1:0]));
  end

  always_comb begin
    q_cmd.kind   = hbs_pkg::KIND_NONE;
    q_cmd.oog    = 1'b0;
    q_cmd.fx     = s2_cx[F-1:0];
    q_cmd.fz     = s2_cz[F-1:0];
    q_cmd.height = s2_height;
    q_addr       = grid_addr;
    unique case (s2_action) inside
      hbs_pkg::ACT_LOAD: begin
        q_addr = ADDR_W'(s2_index);
        if (IDX_CMP_W'(s2_index) >= IDX_CMP_W'(side_sq)) begin
          q_cmd.oog = 1'b1;
        end else begin
          q_cmd.kind = hbs_pkg::KIND_LOAD;
        end
      end
      hbs_pkg::ACT_WORLD, hbs_pkg::ACT_AVERAGE: begin
        if (!x_in || !z_in) begin
          q_cmd.oog = 1'b1;
        end else if (x_last || z_last) begin
          q_cmd.kind = hbs_pkg::KIND_BASE;
        end else if (s2_action == hbs_pkg::ACT_WORLD) begin
          q_cmd.kind = hbs_pkg::KIND_BILINEAR;
        end else begin
          q_cmd.kind = hbs_pkg::KIND_AVERAGE;
        end
      end
      default: begin
        q_cmd.kind = hbs_pkg::KIND_NONE;
      end
    endcase
  end

endmodule

`default_nettype wire

### design/hbs_back.sv
// back end: height store, running min/max, shared lerp unit and result register
`default_nettype none
`include "assert_macros.svh"

module hbs_back #(
  parameter int MAX_SIDE = hbs_pkg::DEF_MAX_SIDE
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic [$clog2(MAX_SIDE+1)-1:0]          side,
  input  logic                                   head_valid,
  input  hbs_pkg::cmd_t                          head_cmd,
  input  logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]   head_addr,
  output logic                                   pop,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [hbs_pkg::OUT_W-1:0]       height_out,
  output logic signed [hbs_pkg::HEIGHT_BITS-1:0] lowest_height,
  output logic signed [hbs_pkg::HEIGHT_BITS-1:0] highest_height,
  output logic                                   out_of_grid
);

  localparam int H_W    = hbs_pkg::HEIGHT_BITS;
  localparam int F      = hbs_pkg::FRAC_BITS;
  localparam int OUT_W  = hbs_pkg::OUT_W;
  localparam int ADDR_W = $clog2(MAX_SIDE * MAX_SIDE);
  localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
  localparam int LERP_W = H_W + F + 2;
  localparam int V_W    = LERP_W + F + 2;
  localparam logic signed [V_W-1:0] RND = V_W'(1) << (F - 1);

  // tap order in the 2x2 neighborhood
  localparam logic [1:0] TAP_H00 = 2'd0;
  localparam logic [1:0] TAP_H10 = 2'd1;
  localparam logic [1:0] TAP_H01 = 2'd2;
  localparam logic [1:0] TAP_H11 = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_WAIT,
    ST_LERP_A,
    ST_LERP_B,
    ST_LERP_C,
    ST_DONE
  } state_t;

  function automatic logic signed [LERP_W-1:0] lerp(
    input logic signed [H_W-1:0] a,
    input logic signed [H_W-1:0] b,
    input logic [F-1:0]          f
  );
    logic signed [H_W:0]      d;
    logic signed [LERP_W-1:0] base;
    logic signed [LERP_W-1:0] p;
    d    = $signed({b[H_W-1], b}) - $signed({a[H_W-1], a});
    base = $signed({{2{a[H_W-1]}}, a, {F{1'b0}}});
    p    = LERP_W'(d) * LERP_W'($signed({1'b0, f}));
    return base + p;
  endfunction

  state_t                   state;
  hbs_pkg::cmd_t            w_cmd;
  logic [ADDR_W-1:0]        w_addr;
  logic [1:0]               rd_cnt;
  logic signed [H_W-1:0]    h_tap [4];
  logic                     cap_valid;
  logic [1:0]               cap_sel;
  logic signed [LERP_W-1:0] acc_a;
  logic signed [LERP_W-1:0] acc_b;
  logic signed [OUT_W-1:0]  result;
  logic signed [H_W-1:0]    run_min;
  logic signed [H_W-1:0]    run_max;

  logic [H_W-1:0]    mem [DEPTH];
  logic [H_W-1:0]    mem_q;
  logic [ADDR_W-1:0] mem_addr;
  logic              mem_we;
  logic              rd_en;
  logic [1:0]        rd_sel;
  logic              read_last;
  logic              is_bil;

  logic signed [H_W-1:0]    lerp_a_in;
  logic signed [H_W-1:0]    lerp_b_in;
  logic [F-1:0]             lerp_f;
  logic signed [LERP_W-1:0] lerp_out;
  logic signed [LERP_W:0]   d2;
  logic signed [V_W-1:0]    v_full;
  logic signed [V_W-1:0]    v_rnd;
  logic signed [LERP_W:0]   avg_sum;
  logic signed [LERP_W:0]   avg_half;
  logic signed [OUT_W-1:0]  bil_res;
  logic signed [OUT_W-1:0]  avg_res;
  logic signed [OUT_W-1:0]  base_res;

  assign pop       = (state == ST_IDLE) && head_valid;
  assign is_bil    = (w_cmd.kind == hbs_pkg::KIND_BILINEAR);
  assign read_last = (rd_cnt == TAP_H11) ||
                     ((rd_cnt == TAP_H01) && (w_cmd.kind == hbs_pkg::KIND_AVERAGE));

  // single store port: writes for loads, one neighbor read per cycle for queries
  always_comb begin
    mem_we   = 1'b0;
    rd_en    = 1'b0;
    rd_sel   = TAP_H00;
    mem_addr = head_addr;
    if (pop) begin
      if (head_cmd.kind == hbs_pkg::KIND_LOAD) begin
        mem_we = 1'b1;
      end else if (head_cmd.kind != hbs_pkg::KIND_NONE) begin
        rd_en = 1'b1;
      end
    end else if (state == ST_READ) begin
      rd_en  = 1'b1;
      rd_sel = rd_cnt;
      case (rd_cnt)
        TAP_H10: mem_addr = w_addr + ADDR_W'(1);
        TAP_H01: mem_addr = w_addr + ADDR_W'(side);
        TAP_H11: mem_addr = w_addr + ADDR_W'(side) + ADDR_W'(1);
        default: mem_addr = w_addr;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= head_cmd.height;
    end
    if (rd_en) begin
      mem_q <= mem[mem_addr];
    end
  end

  // shared lerp: bottom (or x) pass first, then top (or z) pass
  always_comb begin
    if (state == ST_LERP_B && is_bil) begin
      lerp_a_in = h_tap[TAP_H01];
      lerp_b_in = h_tap[TAP_H11];
      lerp_f    = w_cmd.fx;
    end else if (state == ST_LERP_B) begin
      lerp_a_in = h_tap[TAP_H00];
      lerp_b_in = h_tap[TAP_H01];
      lerp_f    = w_cmd.fz;
    end else begin
      lerp_a_in = h_tap[TAP_H00];
      lerp_b_in = h_tap[TAP_H10];
      lerp_f    = w_cmd.fx;
    end
    lerp_out = lerp(lerp_a_in, lerp_b_in, lerp_f);
  end

  // final steps; results stay inside 24 bits for any 16-bit heights
  always_comb begin
    d2       = $signed({acc_b[LERP_W-1], acc_b}) - $signed({acc_a[LERP_W-1], acc_a});
    v_full   = $signed({{2{acc_a[LERP_W-1]}}, acc_a, {F{1'b0}}}) +
               V_W'(d2) * V_W'($signed({1'b0, w_cmd.fz}));
    v_rnd    = (v_full + RND) >>> F;
    bil_res  = v_rnd[OUT_W-1:0];
    avg_sum  = $signed({acc_a[LERP_W-1], acc_a}) + $signed({acc_b[LERP_W-1], acc_b}) +
               $signed((LERP_W+1)'(1));
    avg_half = avg_sum >>> 1;
    avg_res  = avg_half[OUT_W-1:0];
    base_res = OUT_W'($signed({h_tap[TAP_H00], {F{1'b0}}}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cap_valid <= 1'b0;
      out_valid <= 1'b0;
      run_min   <= hbs_pkg::HEIGHT_MAX;
      run_max   <= hbs_pkg::HEIGHT_MIN;
    end else begin
      cap_valid <= rd_en;
      cap_sel   <= rd_sel;
      if (cap_valid) begin
        h_tap[cap_sel] <= mem_q;
      end
      // a beat taken while the next one is ready is refilled in ST_DONE
      if (out_valid && !out_stall && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (head_valid) begin
            w_cmd  <= head_cmd;
            w_addr <= head_addr;
            result <= '0;
            case (head_cmd.kind)
              hbs_pkg::KIND_LOAD: begin
                if (head_cmd.height < run_min) begin
                  run_min <= head_cmd.height;
                end
                if (head_cmd.height > run_max) begin
                  run_max <= head_cmd.height;
                end
                state <= ST_DONE;
              end
              hbs_pkg::KIND_NONE: state <= ST_DONE;
              hbs_pkg::KIND_BASE: state <= ST_WAIT;
              default: begin
                rd_cnt <= TAP_H10;
                state  <= ST_READ;
              end
            endcase
          end
        end
        ST_READ: begin
          if (read_last) begin
            state <= ST_WAIT;
          end else begin
            rd_cnt <= rd_cnt + 2'd1;
          end
        end
        ST_WAIT: begin
          state <= ST_LERP_A;
        end
        ST_LERP_A: begin
          if (w_cmd.kind == hbs_pkg::KIND_BASE) begin
            result <= base_res;
            state  <= ST_DONE;
          end else begin
            acc_a <= lerp_out;
            state <= ST_LERP_B;
          end
        end
        ST_LERP_B: begin
          acc_b <= lerp_out;
          state <= ST_LERP_C;
        end
        ST_LERP_C: begin
          result <= is_bil ? bil_res : avg_res;
          state  <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || !out_stall) begin
            height_out     <= result;
            lowest_height  <= run_min;
            highest_height <= run_max;
            out_of_grid    <= w_cmd.oog;
            out_valid      <= 1'b1;
            state          <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_NEXT(a_minmax_order, clk, rst, mem_we, run_min <= run_max, "min above max after load")
  `ASSERT_IMPLIES(a_taps_settled, clk, rst, state == ST_LERP_A, !cap_valid, "read still in flight")

endmodule

`default_nettype wire

### design/heightmap_bilinear_sampler.sv
// top level of the height grid sampler: config registers, front end, queue, back end
// the back end takes one item at a time and starts the next only after the result is written
// averaged queries read three neighbors, bilinear ones four, edge queries only the base cell
// the pace is set by the single-port height store (one neighbor read a cycle) and one lerp unit
// synchronous rst clears the pipeline, sets side 256, scale 1.0, min 32767 and max -32768
// the height store is not cleared; an entry reads as garbage until it is loaded
`default_nettype none

module heightmap_bilinear_sampler #(
  parameter int MAX_SIDE = hbs_pkg::DEF_MAX_SIDE
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // configuration write port
  input  logic                                   cfg_write,
  input  logic [hbs_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [hbs_pkg::CFG_DATA_W-1:0]         cfg_data,
  // input beats
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [hbs_pkg::ACTION_W-1:0]           action,
  input  logic [hbs_pkg::INDEX_W-1:0]            sample_index,
  input  logic signed [hbs_pkg::HEIGHT_BITS-1:0] sample_height,
  input  logic [hbs_pkg::COORD_W-1:0]            coord_x,
  input  logic [hbs_pkg::COORD_W-1:0]            coord_z,
  // result beats
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [hbs_pkg::OUT_W-1:0]       height_out,
  output logic signed [hbs_pkg::HEIGHT_BITS-1:0] lowest_height,
  output logic signed [hbs_pkg::HEIGHT_BITS-1:0] highest_height,
  output logic                                   out_of_grid
);

  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int ADDR_W = $clog2(MAX_SIDE * MAX_SIDE);
  localparam int SQ_W   = $clog2(MAX_SIDE * MAX_SIDE + 1);
  localparam int GS_W   = hbs_pkg::GRID_SIDE_W;
  localparam int CMP_W  = (GS_W > SIDE_W) ? GS_W : SIDE_W;
  localparam int CMD_W  = $bits(hbs_pkg::cmd_t);
  localparam int Q_W    = CMD_W + ADDR_W;

  // configuration registers
  logic [GS_W-1:0]              grid_side;
  logic [hbs_pkg::SCALE_W-1:0]  inv_scale;

  // effective side, clamped to the supported range, and its square
  logic [CMP_W-1:0]  gs_wide;
  logic [SIDE_W-1:0] side_next;
  logic [SIDE_W-1:0] side;
  logic [SQ_W-1:0]   side_sq;

  // front to queue to back
  logic               q_push;
  logic               q_full;
  logic               q_pop;
  logic               q_empty;
  hbs_pkg::cmd_t      f_cmd;
  logic [ADDR_W-1:0]  f_addr;
  logic [Q_W-1:0]     q_wdata;
  logic [Q_W-1:0]     q_rdata;
  hbs_pkg::cmd_t      head_cmd;
  logic [ADDR_W-1:0]  head_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_side <= hbs_pkg::GRID_SIDE_RST;
      inv_scale <= hbs_pkg::INV_SCALE_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        hbs_pkg::CFG_GRID_SIDE: grid_side <= cfg_data[GS_W-1:0];
        hbs_pkg::CFG_INV_SCALE: inv_scale <= cfg_data[hbs_pkg::SCALE_W-1:0];
      endcase
    end
  end

  // small sides are raised to the minimum, large ones capped at the store side
  always_comb begin
    gs_wide = CMP_W'(grid_side);
    if (gs_wide < CMP_W'(hbs_pkg::MIN_SIDE)) begin
      side_next = SIDE_W'(hbs_pkg::MIN_SIDE);
    end else if (gs_wide > CMP_W'(MAX_SIDE)) begin
      side_next = SIDE_W'(MAX_SIDE);
    end else begin
      side_next = SIDE_W'(gs_wide);
    end
  end

  // side is registered from the clamped setting, and side_sq is registered from side;
  // an item accepted together with a write can still be classified against the old square
  always_ff @(posedge clk) begin
    side    <= side_next;
    side_sq <= SQ_W'(side) * SQ_W'(side);
  end

  hbs_front #(
    .MAX_SIDE (MAX_SIDE)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .action        (action),
    .sample_index  (sample_index),
    .sample_height (sample_height),
    .coord_x       (coord_x),
    .coord_z       (coord_z),
    .inv_scale     (inv_scale),
    .side          (side),
    .side_sq       (side_sq),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (f_cmd),
    .q_addr        (f_addr)
  );

  // queue entry: command on top, store address below
  assign q_wdata   = {f_cmd, f_addr};
  assign head_cmd  = hbs_pkg::cmd_t'(q_rdata[Q_W-1:ADDR_W]);
  assign head_addr = q_rdata[ADDR_W-1:0];

  hbs_queue #(
    .DEPTH (hbs_pkg::QUEUE_DEPTH),
    .WIDTH (Q_W)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // back end owns the store, the min/max and the result register
  hbs_back #(
    .MAX_SIDE (MAX_SIDE)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .side           (side),
    .head_valid     (!q_empty),
    .head_cmd       (head_cmd),
    .head_addr      (head_addr),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .height_out     (height_out),
    .lowest_height  (lowest_height),
    .highest_height (highest_height),
    .out_of_grid    (out_of_grid)
  );

endmodule

`default_nettype wire
